// File: rtl/core/scdc_pkg.sv
// ----------------------------------------------------------------------------
// Straight cell drive controller package
// Shared codes and fixed constants for the straight cell move controller.
// ----------------------------------------------------------------------------
package scdc_pkg;

    // Width of a motor power result.
    localparam int POWER_W        = 16;
    // Width of the cruise speed register.
    localparam int CRUISE_W       = 12;
    // Width of the configuration register index.
    localparam int CFG_INDEX_W    = 3;
    // Width of the move phase code.
    localparam int PHASE_W        = 2;
    localparam int NUM_WHEELS     = 4;

    // Move phase codes.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MOVE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LFWD  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_LBACK = 2'd3;

    // Configuration register indices.
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_SPEED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAVEL_COUNTS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_DISTANCE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_TARGET    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_TARGET   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALL_HOLD      = 3'd7;

    // Wheel positions in the encoder and power arrays.
    localparam int WHEEL_FR = 0;
    localparam int WHEEL_FL = 1;
    localparam int WHEEL_BR = 2;
    localparam int WHEEL_BL = 3;

    // Register reset values.
    localparam int RST_CRUISE_SPEED   = 1200;
    localparam int RST_TRAVEL_COUNTS  = 810;
    localparam int RST_STOP_DISTANCE  = 70;
    localparam int RST_FRONT_LIMIT    = 220;
    localparam int RST_SIDE_THRESHOLD = 300;
    localparam int RST_SIDE_TARGET    = 100;
    localparam int RST_LEVEL_TARGET   = 25;
    localparam int RST_WALL_HOLD      = 30;

    // Gains, offsets and limits.
    localparam int ENC_GAIN     = 4;
    localparam int SIDE_GAIN    = 10;
    localparam int LEVEL_OFFSET = 10;
    localparam int LEVEL_GAIN   = 20;
    localparam int LEVEL_CLAMP  = 1000;
    localparam int POWER_MAX    = 32767;

endpackage

// File: rtl/core/straight_cell_drive_controller_core.sv
// ----------------------------------------------------------------------------
// Straight cell drive controller core
// Drives one straight cell move per control tick stream: encoder and wall
// corrections on the cruise speed, move end detection and front wall levelling.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Carries
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       i_in_valid / o_in_ready   start flag, 4 encoders, 3 ranges
//  out      source     o_out_valid / i_out_ready 4 motor powers, running, phase
//  cfg      sink       i_cfg_valid / o_cfg_ready register index and write data
//
//  One tick is transferred per cycle while the output is not stalled; a result
//  is presented once its input has passed the input register, then the state
//  and result register. The rate is set by the single update of the held state.
//  The synchronous active-low reset loads the register defaults, returns the
//  phase to idle and clears baselines, wall counters and powers.
//  A stalled output holds both stages; the configuration port is always ready.
//
module straight_cell_drive_controller_core #(
    parameter int ENCODER_WIDTH    = 16,
    parameter int RANGE_WIDTH      = 13,
    parameter int TICK_COUNT_WIDTH = 8,
    localparam int CfgW0 = (ENCODER_WIDTH > RANGE_WIDTH) ? ENCODER_WIDTH : RANGE_WIDTH,
    localparam int CfgW1 = (CfgW0 > TICK_COUNT_WIDTH) ? CfgW0 : TICK_COUNT_WIDTH,
    localparam int CFG_DATA_WIDTH = (CfgW1 > scdc_pkg::CRUISE_W) ? CfgW1 : scdc_pkg::CRUISE_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_start_req,
    input  logic [ENCODER_WIDTH-1:0]             i_enc_front_right,
    input  logic [ENCODER_WIDTH-1:0]             i_enc_front_left,
    input  logic [ENCODER_WIDTH-1:0]             i_enc_back_right,
    input  logic [ENCODER_WIDTH-1:0]             i_enc_back_left,
    input  logic [RANGE_WIDTH-1:0]               i_front_range,
    input  logic [RANGE_WIDTH-1:0]               i_right_range,
    input  logic [RANGE_WIDTH-1:0]               i_left_range,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [scdc_pkg::POWER_W-1:0]  o_power_front_right,
    output logic signed [scdc_pkg::POWER_W-1:0]  o_power_front_left,
    output logic signed [scdc_pkg::POWER_W-1:0]  o_power_back_right,
    output logic signed [scdc_pkg::POWER_W-1:0]  o_power_back_left,
    output logic                                 o_running,
    output logic [scdc_pkg::PHASE_W-1:0]         o_phase,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [scdc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]            i_cfg_data
);

    localparam int EW = ENCODER_WIDTH;
    localparam int RW = RANGE_WIDTH;
    localparam int TW = TICK_COUNT_WIDTH;
    localparam int PW = scdc_pkg::POWER_W;
    localparam int NW = scdc_pkg::NUM_WHEELS;
    // Arithmetic width: encoder terms need EW+3 bits, side terms RW+5, plus headroom.
    localparam int AW = ((EW + 3 > RW + 5) ? EW + 3 : RW + 5) + 3;

    // ---------------------------------------------------------------- config
    logic [scdc_pkg::CRUISE_W-1:0] r_cruise_speed;
    logic [EW-1:0]                 r_travel_counts;
    logic [RW-1:0]                 r_stop_distance;
    logic [RW-1:0]                 r_front_wall_limit;
    logic [RW-1:0]                 r_side_wall_threshold;
    logic [RW-1:0]                 r_side_target;
    logic [RW-1:0]                 r_leveling_target;
    logic [TW-1:0]                 r_wall_hold_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise_speed        <= scdc_pkg::CRUISE_W'(scdc_pkg::RST_CRUISE_SPEED);
            r_travel_counts       <= EW'(scdc_pkg::RST_TRAVEL_COUNTS);
            r_stop_distance       <= RW'(scdc_pkg::RST_STOP_DISTANCE);
            r_front_wall_limit    <= RW'(scdc_pkg::RST_FRONT_LIMIT);
            r_side_wall_threshold <= RW'(scdc_pkg::RST_SIDE_THRESHOLD);
            r_side_target         <= RW'(scdc_pkg::RST_SIDE_TARGET);
            r_leveling_target     <= RW'(scdc_pkg::RST_LEVEL_TARGET);
            r_wall_hold_count     <= TW'(scdc_pkg::RST_WALL_HOLD);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                scdc_pkg::CFG_CRUISE_SPEED:   r_cruise_speed <= i_cfg_data[scdc_pkg::CRUISE_W-1:0];
                scdc_pkg::CFG_TRAVEL_COUNTS:  r_travel_counts <= i_cfg_data[EW-1:0];
                scdc_pkg::CFG_STOP_DISTANCE:  r_stop_distance <= i_cfg_data[RW-1:0];
                scdc_pkg::CFG_FRONT_LIMIT:    r_front_wall_limit <= i_cfg_data[RW-1:0];
                scdc_pkg::CFG_SIDE_THRESHOLD: r_side_wall_threshold <= i_cfg_data[RW-1:0];
                scdc_pkg::CFG_SIDE_TARGET:    r_side_target <= i_cfg_data[RW-1:0];
                scdc_pkg::CFG_LEVEL_TARGET:   r_leveling_target <= i_cfg_data[RW-1:0];
                scdc_pkg::CFG_WALL_HOLD:      r_wall_hold_count <= i_cfg_data[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // ----------------------------------------------------------- input stage
    logic          r_s1_valid;
    logic          r_s1_start;
    logic [EW-1:0] r_s1_enc [NW];
    logic [RW-1:0] r_s1_front;
    logic [RW-1:0] r_s1_right;
    logic [RW-1:0] r_s1_left;

    logic          r_out_valid;
    logic          out_free;
    logic          s2_adv;
    logic          in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_start                    <= i_start_req;
            r_s1_enc[scdc_pkg::WHEEL_FR]  <= i_enc_front_right;
            r_s1_enc[scdc_pkg::WHEEL_FL]  <= i_enc_front_left;
            r_s1_enc[scdc_pkg::WHEEL_BR]  <= i_enc_back_right;
            r_s1_enc[scdc_pkg::WHEEL_BL]  <= i_enc_back_left;
            r_s1_front                    <= i_front_range;
            r_s1_right                    <= i_right_range;
            r_s1_left                     <= i_left_range;
        end
    end

    // ------------------------------------------------------------ held state
    logic [scdc_pkg::PHASE_W-1:0] r_phase;
    logic [EW-1:0]                r_base [NW];
    logic [TW-1:0]                r_right_ticks;
    logic [TW-1:0]                r_left_ticks;
    logic signed [PW-1:0]         r_power [NW];
    logic                         r_running;

    logic [scdc_pkg::PHASE_W-1:0] n_phase;
    logic [EW-1:0]                n_base [NW];
    logic [TW-1:0]                n_right_ticks;
    logic [TW-1:0]                n_left_ticks;
    logic signed [PW-1:0]         n_power [NW];
    logic                         n_running;

    // Truncating division towards zero, as the control law expects.
    function automatic logic signed [AW-1:0] half_tz(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] adj;
        adj = $signed({{(AW-1){1'b0}}, v[AW-1]});
        return (v + adj) >>> 1;
    endfunction

    function automatic logic signed [AW-1:0] quarter_tz(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] adj;
        adj = $signed({{(AW-2){1'b0}}, v[AW-1], v[AW-1]});
        return (v + adj) >>> 2;
    endfunction

    function automatic logic signed [PW-1:0] sat_power(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] lim;
        lim = $signed(AW'(scdc_pkg::POWER_MAX));
        if (v > lim) begin
            return PW'(lim);
        end else if (v < -lim) begin
            return PW'(-lim);
        end
        return v[PW-1:0];
    endfunction

    logic signed [EW-1:0] rel [NW];
    logic signed [AW-1:0] fr, fl, br, bl;
    logic signed [AW-1:0] err_fb, err_lr, err_side, side_corr;
    logic signed [AW-1:0] avg, sp;
    logic signed [AW-1:0] front_s, right_s, left_s, target_s, limit_s, lvl_t_s;
    logic signed [AW-1:0] lvl_d, lvl_raw, lvl_clamped, lvl_lim;
    logic                 rc_gt, rc_lt, lc_gt, lc_lt;
    logic                 move_end;

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            n_base[k] = r_s1_start ? r_s1_enc[k] : r_base[k];
            rel[k]    = $signed(r_s1_enc[k] - n_base[k]);
        end
        fr = AW'(rel[scdc_pkg::WHEEL_FR]);
        fl = AW'(rel[scdc_pkg::WHEEL_FL]);
        br = AW'(rel[scdc_pkg::WHEEL_BR]);
        bl = AW'(rel[scdc_pkg::WHEEL_BL]);

        err_fb = (half_tz(fl + fr) - half_tz(bl + br)) * $signed(AW'(scdc_pkg::ENC_GAIN));
        err_lr = (half_tz(bl + fl) - half_tz(br + fr)) * $signed(AW'(scdc_pkg::ENC_GAIN));

        front_s  = $signed(AW'(r_s1_front));
        right_s  = $signed(AW'(r_s1_right));
        left_s   = $signed(AW'(r_s1_left));
        target_s = $signed(AW'(r_side_target));
        limit_s  = $signed(AW'(r_front_wall_limit));
        lvl_t_s  = $signed(AW'(r_leveling_target));

        // Wall counters saturate at all ones and clear as soon as the wall is lost.
        if (r_s1_right < r_side_wall_threshold) begin
            n_right_ticks = (&r_right_ticks) ? r_right_ticks : r_right_ticks + TW'(1);
        end else begin
            n_right_ticks = '0;
        end
        if (r_s1_left < r_side_wall_threshold) begin
            n_left_ticks = (&r_left_ticks) ? r_left_ticks : r_left_ticks + TW'(1);
        end else begin
            n_left_ticks = '0;
        end

        rc_gt = n_right_ticks > r_wall_hold_count;
        rc_lt = n_right_ticks < r_wall_hold_count;
        lc_gt = n_left_ticks > r_wall_hold_count;
        lc_lt = n_left_ticks < r_wall_hold_count;

        if (rc_gt && lc_gt) begin
            side_corr = (right_s - left_s) * $signed(AW'(scdc_pkg::SIDE_GAIN));
        end else if (rc_lt && lc_gt) begin
            side_corr = (target_s - left_s) * $signed(AW'(scdc_pkg::SIDE_GAIN));
        end else if (rc_gt && lc_lt) begin
            side_corr = (right_s - target_s) * $signed(AW'(scdc_pkg::SIDE_GAIN));
        end else begin
            side_corr = '0;
        end
        err_side = -side_corr;

        sp       = $signed(AW'(r_cruise_speed));
        avg      = quarter_tz(fr + fl + br + bl);
        move_end = (avg > $signed(AW'(r_travel_counts))) || (r_s1_front < r_stop_distance);

        n_phase   = r_s1_start ? scdc_pkg::PH_MOVE : r_phase;
        n_running = 1'b1;
        for (int k = 0; k < NW; k++) begin
            n_power[k] = r_power[k];
        end

        unique case (n_phase)
            scdc_pkg::PH_IDLE: begin
                n_running = 1'b0;
            end
            scdc_pkg::PH_MOVE: begin
                n_power[scdc_pkg::WHEEL_FR] = sat_power(sp - err_fb + err_lr + err_side);
                n_power[scdc_pkg::WHEEL_FL] = sat_power(sp - err_fb - err_lr - err_side);
                n_power[scdc_pkg::WHEEL_BR] = sat_power(sp + err_fb + err_lr + err_side);
                n_power[scdc_pkg::WHEEL_BL] = sat_power(sp + err_fb - err_lr - err_side);
                if (move_end) begin
                    for (int k = 0; k < NW; k++) begin
                        n_power[k] = '0;
                    end
                    if (front_s > limit_s) begin
                        n_running = 1'b0;
                        n_phase   = scdc_pkg::PH_IDLE;
                    end else if (front_s > lvl_t_s) begin
                        n_phase = scdc_pkg::PH_LFWD;
                    end else begin
                        n_phase = scdc_pkg::PH_LBACK;
                    end
                end
            end
            default: begin
            end
        endcase

        // Levelling runs in the same tick in which the move ends.
        if (n_phase == scdc_pkg::PH_LFWD) begin
            lvl_d = front_s - $signed(AW'(scdc_pkg::LEVEL_OFFSET));
        end else begin
            lvl_d = front_s + $signed(AW'(scdc_pkg::LEVEL_OFFSET));
        end
        lvl_raw = (lvl_d - lvl_t_s) * $signed(AW'(scdc_pkg::LEVEL_GAIN));
        lvl_lim = $signed(AW'(scdc_pkg::LEVEL_CLAMP));
        if (lvl_raw > lvl_lim) begin
            lvl_clamped = lvl_lim;
        end else if (lvl_raw < -lvl_lim) begin
            lvl_clamped = -lvl_lim;
        end else begin
            lvl_clamped = lvl_raw;
        end

        if ((n_phase == scdc_pkg::PH_LFWD && (lvl_d < lvl_t_s || lvl_d > limit_s)) ||
            (n_phase == scdc_pkg::PH_LBACK && (lvl_d > lvl_t_s || lvl_d > limit_s))) begin
            n_running = 1'b0;
            n_phase   = scdc_pkg::PH_IDLE;
        end else if (n_phase == scdc_pkg::PH_LFWD || n_phase == scdc_pkg::PH_LBACK) begin
            for (int k = 0; k < NW; k++) begin
                n_power[k] = lvl_clamped[PW-1:0];
            end
        end
    end

    // The held state doubles as the result register: it only moves when the
    // previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_phase       <= scdc_pkg::PH_IDLE;
            r_right_ticks <= '0;
            r_left_ticks  <= '0;
            r_running     <= 1'b0;
            for (int k = 0; k < NW; k++) begin
                r_base[k]  <= '0;
                r_power[k] <= '0;
            end
        end else begin
            if (s2_adv) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_right_ticks <= n_right_ticks;
                r_left_ticks  <= n_left_ticks;
                r_running     <= n_running;
                for (int k = 0; k < NW; k++) begin
                    r_base[k]  <= n_base[k];
                    r_power[k] <= n_power[k];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_power_front_right = r_power[scdc_pkg::WHEEL_FR];
    assign o_power_front_left  = r_power[scdc_pkg::WHEEL_FL];
    assign o_power_back_right  = r_power[scdc_pkg::WHEEL_BR];
    assign o_power_back_left   = r_power[scdc_pkg::WHEEL_BL];
    assign o_running           = r_running;
    assign o_phase             = r_phase;

endmodule

// File: verif/straight_cell_drive_controller_core_test.sv
// ----------------------------------------------------------------------------
// Straight cell drive controller core testbench
// Drives control ticks through the core and checks every result against a
// cycle-free model of the move, levelling and wall-counter behaviour. Short
// directed ticks come first, then randomised cell moves and noise under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module straight_cell_drive_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENC_W       = 16;
    localparam int RNG_W       = 13;
    localparam int TICK_W      = 8;
    localparam int CFG_DW      = 16;
    localparam int RNG_MAX     = (1 << RNG_W) - 1;
    localparam int GAP_PERCENT = 29;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NWH         = scdc_pkg::NUM_WHEELS;
    localparam int PWR_W       = scdc_pkg::POWER_W;
    localparam int PH_W        = scdc_pkg::PHASE_W;
    localparam int IDX_W       = scdc_pkg::CFG_INDEX_W;

    typedef struct packed {
        logic                      start;
        logic [NWH-1:0][ENC_W-1:0] enc;
        logic [RNG_W-1:0]          front_mm;
        logic [RNG_W-1:0]          right_mm;
        logic [RNG_W-1:0]          left_mm;
    } t_drive_tick;

    typedef struct packed {
        logic [NWH-1:0][PWR_W-1:0] power;
        logic                      running;
        logic [PH_W-1:0]           phase;
    } t_drive_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_start_req;
    logic [ENC_W-1:0]                i_enc_front_right;
    logic [ENC_W-1:0]                i_enc_front_left;
    logic [ENC_W-1:0]                i_enc_back_right;
    logic [ENC_W-1:0]                i_enc_back_left;
    logic [RNG_W-1:0]                i_front_range;
    logic [RNG_W-1:0]                i_right_range;
    logic [RNG_W-1:0]                i_left_range;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic signed [PWR_W-1:0]         o_power_front_right;
    logic signed [PWR_W-1:0]         o_power_front_left;
    logic signed [PWR_W-1:0]         o_power_back_right;
    logic signed [PWR_W-1:0]         o_power_back_left;
    logic                            o_running;
    logic [PH_W-1:0]                 o_phase;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [IDX_W-1:0]                i_cfg_index;
    logic [CFG_DW-1:0]               i_cfg_data;

    straight_cell_drive_controller_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_start_req         (i_start_req),
        .i_enc_front_right   (i_enc_front_right),
        .i_enc_front_left    (i_enc_front_left),
        .i_enc_back_right    (i_enc_back_right),
        .i_enc_back_left     (i_enc_back_left),
        .i_front_range       (i_front_range),
        .i_right_range       (i_right_range),
        .i_left_range        (i_left_range),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_power_front_right (o_power_front_right),
        .o_power_front_left  (o_power_front_left),
        .o_power_back_right  (o_power_back_right),
        .o_power_back_left   (o_power_back_left),
        .o_running           (o_running),
        .o_phase             (o_phase),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Register copies and held state of the move controller.
    int reg_cruise, reg_travel, reg_stop, reg_flimit;
    int reg_side_thr, reg_side_target, reg_level, reg_hold;
    logic [PH_W-1:0]           move_ph;
    logic [NWH-1:0][ENC_W-1:0] enc_base;
    logic [TICK_W-1:0]         right_ticks, left_ticks;
    logic [NWH-1:0][PWR_W-1:0] held_power;

    t_drive_tick   tick_q[$];
    t_drive_result power_q[$];
    t_drive_tick   cur_tick;
    bit            tick_taken;
    bit            no_gaps;
    bit            right_near, left_near;
    int            hold_left;
    int            cycles, ticks_queued, ticks_sent, results_seen, moves, settings;
    int            mismatches;
    bit [3:0]      phases_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, power_q.size());
            $display("straight_cell_drive_controller_core test failed");
            $finish;
        end
    end

    task automatic reset_model();
        reg_cruise      = scdc_pkg::RST_CRUISE_SPEED;
        reg_travel      = scdc_pkg::RST_TRAVEL_COUNTS;
        reg_stop        = scdc_pkg::RST_STOP_DISTANCE;
        reg_flimit      = scdc_pkg::RST_FRONT_LIMIT;
        reg_side_thr    = scdc_pkg::RST_SIDE_THRESHOLD;
        reg_side_target = scdc_pkg::RST_SIDE_TARGET;
        reg_level       = scdc_pkg::RST_LEVEL_TARGET;
        reg_hold        = scdc_pkg::RST_WALL_HOLD;
        move_ph         = scdc_pkg::PH_IDLE;
        enc_base        = '0;
        right_ticks     = '0;
        left_ticks      = '0;
        held_power      = '0;
    endtask

    function automatic logic [PWR_W-1:0] clip_power(longint v);
        if (v > scdc_pkg::POWER_MAX)
            return PWR_W'(scdc_pkg::POWER_MAX);
        if (v < -scdc_pkg::POWER_MAX)
            return PWR_W'(-scdc_pkg::POWER_MAX);
        return PWR_W'(v);
    endfunction

    function automatic logic [PWR_W-1:0] level_power(longint d);
        longint s;
        s = (d - reg_level) * scdc_pkg::LEVEL_GAIN;
        if (s > scdc_pkg::LEVEL_CLAMP)
            s = scdc_pkg::LEVEL_CLAMP;
        if (s < -scdc_pkg::LEVEL_CLAMP)
            s = -scdc_pkg::LEVEL_CLAMP;
        return PWR_W'(s);
    endfunction

    // Advances the move state by one control tick and returns the motor result.
    function automatic t_drive_result predict_drive(t_drive_tick t);
        longint           rel [NWH];
        longint           err_fb, err_lr, corr, avg, sp, d, front, right, left, rc, lc;
        logic [ENC_W-1:0] diff;
        bit               finished;
        int               w;
        t_drive_result    r;

        front = t.front_mm;
        right = t.right_mm;
        left  = t.left_mm;
        if (t.start) begin
            enc_base = t.enc;
            move_ph  = scdc_pkg::PH_MOVE;
        end
        for (w = 0; w < NWH; w++) begin
            diff   = t.enc[w] - enc_base[w];
            rel[w] = $signed(diff);
        end
        err_fb = -(((rel[scdc_pkg::WHEEL_BL] + rel[scdc_pkg::WHEEL_BR]) / 2)
                   - ((rel[scdc_pkg::WHEEL_FL] + rel[scdc_pkg::WHEEL_FR]) / 2))
                 * scdc_pkg::ENC_GAIN;
        err_lr = (((rel[scdc_pkg::WHEEL_BL] + rel[scdc_pkg::WHEEL_FL]) / 2)
                  - ((rel[scdc_pkg::WHEEL_BR] + rel[scdc_pkg::WHEEL_FR]) / 2))
                 * scdc_pkg::ENC_GAIN;

        // Wall counters run in every phase and are not cleared by a start.
        right_ticks = (right < reg_side_thr) ?
                      ((right_ticks == '1) ? right_ticks : right_ticks + 1'b1) : '0;
        left_ticks  = (left < reg_side_thr) ?
                      ((left_ticks == '1) ? left_ticks : left_ticks + 1'b1) : '0;
        rc = right_ticks;
        lc = left_ticks;
        corr = 0;
        if (rc > reg_hold && lc > reg_hold)
            corr = (right - left) * scdc_pkg::SIDE_GAIN;
        else if (rc < reg_hold && lc > reg_hold)
            corr = (reg_side_target - left) * scdc_pkg::SIDE_GAIN;
        else if (rc > reg_hold && lc < reg_hold)
            corr = (right - reg_side_target) * scdc_pkg::SIDE_GAIN;

        finished = 1'b0;
        if (move_ph == scdc_pkg::PH_IDLE) begin
            finished = 1'b1;
        end else if (move_ph == scdc_pkg::PH_MOVE) begin
            sp = reg_cruise;
            held_power[scdc_pkg::WHEEL_FR] = clip_power(sp - err_fb + err_lr - corr);
            held_power[scdc_pkg::WHEEL_FL] = clip_power(sp - err_fb - err_lr + corr);
            held_power[scdc_pkg::WHEEL_BR] = clip_power(sp + err_fb + err_lr - corr);
            held_power[scdc_pkg::WHEEL_BL] = clip_power(sp + err_fb - err_lr + corr);
            avg = (rel[scdc_pkg::WHEEL_FR] + rel[scdc_pkg::WHEEL_FL]
                   + rel[scdc_pkg::WHEEL_BR] + rel[scdc_pkg::WHEEL_BL]) / 4;
            if (avg > reg_travel || front < reg_stop) begin
                held_power = '0;
                if (front > reg_flimit) begin
                    finished = 1'b1;
                    move_ph  = scdc_pkg::PH_IDLE;
                end else if (front > reg_level) begin
                    move_ph = scdc_pkg::PH_LFWD;
                end else begin
                    move_ph = scdc_pkg::PH_LBACK;
                end
            end
        end

        // Levelling starts in the very tick that ends the move.
        if (move_ph == scdc_pkg::PH_LFWD || move_ph == scdc_pkg::PH_LBACK) begin
            d = (move_ph == scdc_pkg::PH_LFWD) ? front - scdc_pkg::LEVEL_OFFSET
                                               : front + scdc_pkg::LEVEL_OFFSET;
            if (d > reg_flimit || (move_ph == scdc_pkg::PH_LFWD && d < reg_level)
                    || (move_ph == scdc_pkg::PH_LBACK && d > reg_level)) begin
                finished = 1'b1;
                move_ph  = scdc_pkg::PH_IDLE;
            end else begin
                for (w = 0; w < NWH; w++)
                    held_power[w] = level_power(d);
            end
        end

        r.power   = held_power;
        r.running = !finished;
        r.phase   = move_ph;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input channel: a new tick is presented on the falling edge once the
    // previous transfer has completed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            power_q.push_back(predict_drive(cur_tick));
            tick_taken = 1'b1;
            ticks_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tick_taken) begin
            tick_taken = 1'b0;
            if (tick_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT)) begin
                cur_tick = tick_q.pop_front();
                i_start_req       <= cur_tick.start;
                i_enc_front_right <= cur_tick.enc[scdc_pkg::WHEEL_FR];
                i_enc_front_left  <= cur_tick.enc[scdc_pkg::WHEEL_FL];
                i_enc_back_right  <= cur_tick.enc[scdc_pkg::WHEEL_BR];
                i_enc_back_left   <= cur_tick.enc[scdc_pkg::WHEEL_BL];
                i_front_range     <= cur_tick.front_mm;
                i_right_range     <= cur_tick.right_mm;
                i_left_range      <= cur_tick.left_mm;
                i_in_valid        <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output channel: random back-pressure, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    task automatic flag_field(string name, longint want_v, longint got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("Result %0d: %s expected %0d, got %0d", results_seen, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_drive_result got, want;
        int            w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.power[scdc_pkg::WHEEL_FR] = o_power_front_right;
            got.power[scdc_pkg::WHEEL_FL] = o_power_front_left;
            got.power[scdc_pkg::WHEEL_BR] = o_power_back_right;
            got.power[scdc_pkg::WHEEL_BL] = o_power_back_left;
            got.running                   = o_running;
            got.phase                     = o_phase;
            if (power_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d arrived with no tick outstanding", results_seen);
            end else begin
                want = power_q.pop_front();
                phases_seen[want.phase] = 1'b1;
                for (w = 0; w < NWH; w++)
                    if (got.power[w] !== want.power[w])
                        flag_field($sformatf("power of wheel %0d", w),
                                   $signed(want.power[w]), $signed(got.power[w]));
                if (got.running !== want.running)
                    flag_field("running", want.running, got.running);
                if (got.phase !== want.phase)
                    flag_field("phase", want.phase, got.phase);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DW'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            scdc_pkg::CFG_CRUISE_SPEED:   reg_cruise      = val & 12'hFFF;
            scdc_pkg::CFG_TRAVEL_COUNTS:  reg_travel      = val & 16'hFFFF;
            scdc_pkg::CFG_STOP_DISTANCE:  reg_stop        = val & RNG_MAX;
            scdc_pkg::CFG_FRONT_LIMIT:    reg_flimit      = val & RNG_MAX;
            scdc_pkg::CFG_SIDE_THRESHOLD: reg_side_thr    = val & RNG_MAX;
            scdc_pkg::CFG_SIDE_TARGET:    reg_side_target = val & RNG_MAX;
            scdc_pkg::CFG_LEVEL_TARGET:   reg_level       = val & RNG_MAX;
            scdc_pkg::CFG_WALL_HOLD:      reg_hold        = val & 8'hFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(int cruise, int travel, int stop, int flimit,
                             int thr, int target, int level, int hold);
        settings++;
        write_reg(scdc_pkg::CFG_CRUISE_SPEED, cruise);
        write_reg(scdc_pkg::CFG_TRAVEL_COUNTS, travel);
        write_reg(scdc_pkg::CFG_STOP_DISTANCE, stop);
        write_reg(scdc_pkg::CFG_FRONT_LIMIT, flimit);
        write_reg(scdc_pkg::CFG_SIDE_THRESHOLD, thr);
        write_reg(scdc_pkg::CFG_SIDE_TARGET, target);
        write_reg(scdc_pkg::CFG_LEVEL_TARGET, level);
        write_reg(scdc_pkg::CFG_WALL_HOLD, hold);
    endtask

    // Waits until every queued tick has been transferred and answered, then
    // lets the two pipeline stages settle.
    task automatic wait_drained();
        while (tick_q.size() != 0 || i_in_valid || power_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [RNG_W-1:0] clamp_range(int v);
        if (v < 0)
            return '0;
        if (v > RNG_MAX)
            return '1;
        return RNG_W'(v);
    endfunction

    function automatic logic [RNG_W-1:0] side_range(bit near);
        if (near)
            return (reg_side_thr == 0) ? '0 : RNG_W'($urandom_range(0, reg_side_thr - 1));
        return RNG_W'($urandom_range(reg_side_thr, RNG_MAX));
    endfunction

    task automatic push_raw(bit start, logic [ENC_W-1:0] fr, logic [ENC_W-1:0] fl,
                            logic [ENC_W-1:0] br, logic [ENC_W-1:0] bl,
                            int front, int right, int left);
        t_drive_tick t;
        t.start                  = start;
        t.enc[scdc_pkg::WHEEL_FR] = fr;
        t.enc[scdc_pkg::WHEEL_FL] = fl;
        t.enc[scdc_pkg::WHEEL_BR] = br;
        t.enc[scdc_pkg::WHEEL_BL] = bl;
        t.front_mm               = clamp_range(front);
        t.right_mm               = clamp_range(right);
        t.left_mm                = clamp_range(left);
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    task automatic push_tick(bit start, logic [NWH-1:0][ENC_W-1:0] pos, int front);
        push_raw(start, pos[scdc_pkg::WHEEL_FR], pos[scdc_pkg::WHEEL_FL],
                 pos[scdc_pkg::WHEEL_BR], pos[scdc_pkg::WHEEL_BL],
                 front, side_range(right_near), side_range(left_near));
    endtask

    // One cell move: a start, ticks that advance the encoders with some skew
    // until travel or the front wall ends it, then a few ticks near the
    // levelling target.
    task automatic queue_move();
        logic [NWH-1:0][ENC_W-1:0] pos;
        int n, adv, f, fstep, k, w, lv;
        bit by_front;
        moves++;
        if ($urandom_range(0, 99) < 30)
            right_near = !right_near;
        if ($urandom_range(0, 99) < 30)
            left_near = !left_near;
        for (w = 0; w < NWH; w++)
            pos[w] = ENC_W'($urandom);
        n     = $urandom_range(3, 40);
        adv   = reg_travel / n + 1;
        if (adv > 8000)
            adv = 8000;
        fstep = 0;
        by_front = ($urandom_range(0, 2) == 0);
        if (by_front) begin
            f     = reg_stop + $urandom_range(0, 600);
            fstep = (f - reg_stop) / n + 1;
        end else if ($urandom_range(0, 1) == 1) begin
            f = $urandom_range(reg_stop, RNG_MAX);
        end else begin
            f = $urandom_range(reg_stop, (reg_flimit > reg_stop) ? reg_flimit : reg_stop);
        end
        push_tick(1'b1, pos, f);
        for (k = 0; k < n + 2; k++) begin
            for (w = 0; w < NWH; w++) begin
                if ($urandom_range(0, 99) < 3)
                    pos[w] = ENC_W'($urandom);
                else
                    pos[w] = pos[w] + ENC_W'(adv + $urandom_range(0, 10) - 5);
            end
            if (by_front)
                f = f - fstep;
            else
                f = f + $urandom_range(0, 20) - 10;
            if ($urandom_range(0, 99) < 5)
                right_near = !right_near;
            if ($urandom_range(0, 99) < 5)
                left_near = !left_near;
            push_tick(1'b0, pos, f);
        end
        lv = $urandom_range(0, 6);
        for (k = 0; k < lv; k++)
            push_tick(1'b0, pos, reg_level + $urandom_range(0, 60) - 25);
    endtask

    task automatic fill_random(int count);
        int goal;
        goal = ticks_queued + count;
        while (ticks_queued < goal) begin
            if ($urandom_range(0, 99) < 15)
                push_raw($urandom_range(0, 99) < 20, ENC_W'($urandom), ENC_W'($urandom),
                         ENC_W'($urandom), ENC_W'($urandom), $urandom_range(0, RNG_MAX),
                         $urandom_range(0, RNG_MAX), $urandom_range(0, RNG_MAX));
            else
                queue_move();
        end
    endtask

    initial begin
        logic [ENC_W-1:0] b;
        int               leftover, waited;

        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_start_req       = 1'b0;
        i_enc_front_right = '0;
        i_enc_front_left  = '0;
        i_enc_back_right  = '0;
        i_enc_back_left   = '0;
        i_front_range     = '0;
        i_right_range     = '0;
        i_left_range      = '0;
        i_out_ready       = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = scdc_pkg::CFG_CRUISE_SPEED;
        i_cfg_data        = '0;
        reset_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks with a short wall hold so the centering cases show up.
        write_reg(scdc_pkg::CFG_WALL_HOLD, 3);
        b = 16'hFFF0;
        push_raw(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, RNG_MAX, RNG_MAX, RNG_MAX);
        push_raw(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        push_raw(1, b, b, b, b, RNG_MAX, 10, 20);
        // Wall counters sit exactly at the hold count here: no centering.
        push_raw(0, b + 16'd40, b + 16'd20, b + 16'd8, b, 4000, 10, 20);
        push_raw(0, b + 16'd60, b + 16'd50, b + 16'd30, b + 16'd55, 4000, 10, 20);
        push_raw(0, b + 16'd70, b + 16'd60, b + 16'd45, b + 16'd65, 4000, RNG_MAX, 20);
        // Opposite half-range skew drives every power into saturation.
        push_raw(0, b + 16'h7FFF, b + 16'h7FFF, b + 16'h8000, b + 16'h8000, 4000, 50, 20);
        push_raw(0, b + 16'd900, b + 16'd900, b + 16'd900, b + 16'd900, 500, 50, 20);
        push_raw(0, b, b, b, b, 60, 50, 20);
        push_raw(1, 16'h1234, 16'h1234, 16'h1234, 16'h1234, RNG_MAX, RNG_MAX, RNG_MAX);
        push_raw(0, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 60, RNG_MAX, RNG_MAX);
        push_raw(0, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 200, RNG_MAX, RNG_MAX);
        push_raw(0, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 20, RNG_MAX, RNG_MAX);
        push_raw(1, 16'h0100, 16'h0200, 16'h0300, 16'h0400, RNG_MAX, RNG_MAX, RNG_MAX);
        push_raw(0, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 10, RNG_MAX, RNG_MAX);
        push_raw(0, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 0, RNG_MAX, RNG_MAX);
        push_raw(0, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 16, RNG_MAX, RNG_MAX);
        push_raw(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 100, 0, 0);
        push_raw(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 65, 0, 0);
        push_raw(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 235, 0, 0);
        push_raw(1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, RNG_MAX, 0, RNG_MAX);
        // A start while already moving takes fresh baselines.
        push_raw(1, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, RNG_MAX, 0, RNG_MAX);
        push_raw(0, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 70, 0, RNG_MAX);
        push_raw(0, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 69, 0, RNG_MAX);
        push_raw(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, RNG_MAX, 0, RNG_MAX);
        wait_drained();

        // Register defaults, with a pause part way through.
        write_all(scdc_pkg::RST_CRUISE_SPEED, scdc_pkg::RST_TRAVEL_COUNTS,
                  scdc_pkg::RST_STOP_DISTANCE, scdc_pkg::RST_FRONT_LIMIT,
                  scdc_pkg::RST_SIDE_THRESHOLD, scdc_pkg::RST_SIDE_TARGET,
                  scdc_pkg::RST_LEVEL_TARGET, scdc_pkg::RST_WALL_HOLD);
        fill_random(100);
        wait_drained();
        fill_random(100);
        wait_drained();

        write_all(4095, 65535, 0, RNG_MAX, RNG_MAX, 0, 0, 0);
        fill_random(105);
        wait_drained();

        write_all(0, 0, RNG_MAX, 0, 0, RNG_MAX, RNG_MAX, 255);
        fill_random(70);
        wait_drained();

        // Random settings; the receiver holds off long enough for the core
        // to fill and push back on the input.
        write_all($urandom_range(0, 4095), $urandom_range(0, 3000), $urandom_range(0, 400),
                  $urandom_range(0, 1000), $urandom_range(0, 2000), $urandom_range(0, 500),
                  $urandom_range(0, 300), $urandom_range(0, 40));
        hold_left = 300;
        fill_random(180);
        wait_drained();

        // Short moves at full rate on both channels.
        write_all(2000, 100, 150, 600, 400, 150, 80, 2);
        no_gaps = 1'b1;
        fill_random(180);
        while (tick_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        waited = 0;
        while (power_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        leftover = power_q.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("Covered %0d control ticks (%0d generated moves) under %0d register settings",
                 ticks_sent, moves, settings);
        $display("Phase codes reached, idle to levelling back: %b%b%b%b, %0d mismatches",
                 phases_seen[scdc_pkg::PH_IDLE], phases_seen[scdc_pkg::PH_MOVE],
                 phases_seen[scdc_pkg::PH_LFWD], phases_seen[scdc_pkg::PH_LBACK], mismatches);
        if (mismatches == 0 && leftover == 0)
            $display("straight_cell_drive_controller_core test passed");
        else
            $display("straight_cell_drive_controller_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/scdc_pkg.sv
rtl/core/straight_cell_drive_controller_core.sv
verif/straight_cell_drive_controller_core_test.sv
